### hw/rtl/info_frame_stuffing_framer_top_macros.svh
// Assertion macros used by the checker file of the framer.
`ifndef INFO_FRAME_STUFFING_FRAMER_TOP_MACROS_SVH
`define INFO_FRAME_STUFFING_FRAMER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define IFSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define IFSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed");

`endif

### hw/rtl/ifsf_pkg.sv
package ifsf_pkg;

    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLAG       = 3'd0,
        CFG_ADDRESS    = 3'd1,
        CFG_ESCAPE     = 3'd2,
        CFG_FLAG_SUB   = 3'd3,
        CFG_ESCAPE_SUB = 3'd4
    } ifsf_cfg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_FLAG       = 8'd126;
    localparam logic [7:0] RST_ADDRESS    = 8'd3;
    localparam logic [7:0] RST_ESCAPE     = 8'd125;
    localparam logic [7:0] RST_FLAG_SUB   = 8'd94;
    localparam logic [7:0] RST_ESCAPE_SUB = 8'd93;

    typedef struct packed {
        logic [7:0] flag;
        logic [7:0] address;
        logic [7:0] escape;
        logic [7:0] flag_sub;
        logic [7:0] escape_sub;
    } ifsf_cfg_t;

    // How a payload byte goes onto the line.
    typedef enum logic [1:0] {
        KIND_PLAIN  = 2'd0,
        KIND_FLAG   = 2'd1,
        KIND_ESCAPE = 2'd2
    } ifsf_kind_t;

    // One classified payload byte, as queued between front and back.
    typedef struct packed {
        logic       hdr;
        logic [7:0] ctrl;
        ifsf_kind_t kind;
        logic [7:0] data;
        logic       last;
        logic [7:0] bcc;
    } ifsf_entry_t;

    // Output slots of one entry, in line order.
    typedef logic [2:0] ifsf_slot_t;

    localparam ifsf_slot_t SLOT_OPEN_FLAG = 3'd0;
    localparam ifsf_slot_t SLOT_ADDRESS   = 3'd1;
    localparam ifsf_slot_t SLOT_CONTROL   = 3'd2;
    localparam ifsf_slot_t SLOT_BCC1      = 3'd3;
    localparam ifsf_slot_t SLOT_DATA      = 3'd4;
    localparam ifsf_slot_t SLOT_SUBST     = 3'd5;
    localparam ifsf_slot_t SLOT_BCC2      = 3'd6;
    localparam ifsf_slot_t SLOT_CLOSE     = 3'd7;

    // Lowest enabled slot at or above start. The data slot is always enabled.
    function automatic ifsf_slot_t first_from(logic [7:0] mask, ifsf_slot_t start);
        ifsf_slot_t idx;
        idx = SLOT_DATA;
        for (int i = 7; i >= 0; i--) begin
            if (mask[i] && (3'(i) >= start)) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // True when some slot above idx is enabled.
    function automatic logic more_after(logic [7:0] mask, ifsf_slot_t idx);
        logic [7:0] above;
        above = (mask >> idx) >> 1;
        return |above;
    endfunction

endpackage

### hw/rtl/ifsf_front.sv
module ifsf_front
    import ifsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  payload_byte,
    input  logic [7:0]  control_byte,
    input  logic        frame_end,
    input  ifsf_cfg_t   cfg,
    output ifsf_entry_t entry
);

    logic       inside_frame_reg;
    logic       inside_frame_next;
    logic [7:0] parity_reg;
    logic [7:0] parity_next;
    logic [7:0] parity_base;
    logic [7:0] parity_sum;

    // A frame's parity starts from zero on its first byte.
    assign parity_base = inside_frame_reg ? parity_reg : 8'd0;
    assign parity_sum  = parity_base ^ payload_byte;

    always_comb
    begin
        entry.hdr  = !inside_frame_reg;
        entry.ctrl = control_byte;
        entry.data = payload_byte;
        entry.last = frame_end;
        entry.bcc  = parity_sum;
        // The flag rule wins when flag and escape hold the same value.
        if (payload_byte == cfg.flag) begin
            entry.kind = KIND_FLAG;
        end
        else if (payload_byte == cfg.escape) begin
            entry.kind = KIND_ESCAPE;
        end
        else begin
            entry.kind = KIND_PLAIN;
        end
    end

    always_comb
    begin
        inside_frame_next = inside_frame_reg;
        parity_next       = parity_reg;
        if (accept) begin
            inside_frame_next = !frame_end;
            parity_next       = frame_end ? 8'd0 : parity_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            inside_frame_reg <= 1'b0;
            parity_reg       <= 8'd0;
        end
        else begin
            inside_frame_reg <= inside_frame_next;
            parity_reg       <= parity_next;
        end
    end

endmodule

### hw/rtl/ifsf_queue.sv
module ifsf_queue
    import ifsf_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  ifsf_entry_t wr_entry,
    input  logic        rd_en,
    output ifsf_entry_t rd_entry,
    output logic        full,
    output logic        empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ifsf_entry_t      slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

### hw/rtl/ifsf_back.sv
module ifsf_back
    import ifsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  ifsf_entry_t head,
    input  ifsf_cfg_t   cfg,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  line_byte,
    output logic        run_last
);

    ifsf_slot_t slot_reg;
    ifsf_slot_t slot_next;
    ifsf_slot_t cur;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] line_byte_reg;
    logic       run_last_reg;
    logic [7:0] mask;
    logic       more;
    logic       load;
    logic [7:0] slot_byte;

    assign mask = {head.last, head.last, (head.kind != KIND_PLAIN), 1'b1,
                   head.hdr, head.hdr, head.hdr, head.hdr};
    assign cur  = first_from(mask, slot_reg);
    assign more = more_after(mask, cur);
    assign load = head_valid && (!out_valid_reg || !out_stall);
    assign pop  = load && !more;

    always_comb
    begin
        case (cur)
            SLOT_OPEN_FLAG: slot_byte = cfg.flag;
            SLOT_ADDRESS:   slot_byte = cfg.address;
            SLOT_CONTROL:   slot_byte = head.ctrl;
            SLOT_BCC1:      slot_byte = cfg.address ^ head.ctrl;
            SLOT_DATA:      slot_byte = (head.kind == KIND_PLAIN) ? head.data : cfg.escape;
            SLOT_SUBST:     slot_byte = (head.kind == KIND_FLAG) ? cfg.flag_sub
                                                                 : cfg.escape_sub;
            SLOT_BCC2:      slot_byte = head.bcc;
            SLOT_CLOSE:     slot_byte = cfg.flag;
            default:        slot_byte = cfg.flag;
        endcase
    end

    always_comb
    begin
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load) begin
            slot_next      = more ? cur + 1'b1 : SLOT_OPEN_FLAG;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slot_reg      <= SLOT_OPEN_FLAG;
            out_valid_reg <= 1'b0;
        end
        else begin
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            line_byte_reg <= slot_byte;
            run_last_reg  <= !more;
        end
    end

    assign out_valid = out_valid_reg;
    assign line_byte = line_byte_reg;
    assign run_last  = run_last_reg;

endmodule

### hw/rtl/info_frame_stuffing_framer_top.sv
// Byte-stuffing information-frame framer.
// Input channel (in_valid, in_stall): one raw payload byte per transaction with its
// frame's control byte and a frame_end mark on the last byte of the frame. The first
// byte of a frame produces the header (flag, address, control, address XOR control)
// before its own bytes; frame_end adds the raw BCC2 parity byte and a closing flag.
// Output channel (out_valid, out_stall): one line byte per transaction; run_last marks
// the final byte produced by an input transaction. One input makes 1 to 8 line bytes.
// Throughput: the output link carries one byte per cycle while out_stall is low, and
// a stuffed byte makes two line bytes. Input transactions are taken every cycle
// while the QUEUE_DEPTH-entry queue between front and back has room.
// Path: an accepted item is written into the queue, and its first byte is loaded from
// the queue head into the output register once that register is free.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready; writes to
// indexes beyond the five registers are dropped. Write only while the block is idle.
// Reset clears frame state, the queue and the output valid flag, and loads the default
// flag, address, escape and substitute values. A stalled receiver holds the output byte;
// the queue keeps accepting input until it fills, then in_stall rises.
module info_frame_stuffing_framer_top
    import ifsf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           payload_byte,
    input  logic [7:0]           control_byte,
    input  logic                 frame_end,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           line_byte,
    output logic                 run_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    ifsf_cfg_t   cfg_reg;
    ifsf_cfg_t   cfg_next;
    ifsf_entry_t front_entry;
    ifsf_entry_t head_entry;
    logic        accept;
    logic        queue_full;
    logic        queue_empty;
    logic        pop;

    // The configuration port never pushes back.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FLAG:       cfg_next.flag       = cfg_data;
                CFG_ADDRESS:    cfg_next.address    = cfg_data;
                CFG_ESCAPE:     cfg_next.escape     = cfg_data;
                CFG_FLAG_SUB:   cfg_next.flag_sub   = cfg_data;
                CFG_ESCAPE_SUB: cfg_next.escape_sub = cfg_data;
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.flag       <= RST_FLAG;
            cfg_reg.address    <= RST_ADDRESS;
            cfg_reg.escape     <= RST_ESCAPE;
            cfg_reg.flag_sub   <= RST_FLAG_SUB;
            cfg_reg.escape_sub <= RST_ESCAPE_SUB;
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

    // The input side stalls only when the queue is full.
    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;

    // Front: keeps frame and parity state and classifies each byte.
    ifsf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .payload_byte (payload_byte),
        .control_byte (control_byte),
        .frame_end    (frame_end),
        .cfg          (cfg_reg),
        .entry        (front_entry)
    );

    // Short queue that lets the front run ahead of a stalled back end.
    ifsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_entry (front_entry),
        .rd_en    (pop),
        .rd_entry (head_entry),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // Back: walks the line bytes of the head entry, one per cycle while out_stall is
    // low, into the output register.
    ifsf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!queue_empty),
        .head       (head_entry),
        .cfg        (cfg_reg),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .line_byte  (line_byte),
        .run_last   (run_last)
    );

endmodule

### hw/rtl/ifsf_checker.sv
`include "info_frame_stuffing_framer_top_macros.svh"

module ifsf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] line_byte,
    input logic       run_last
);

    // A held output transaction keeps its byte and its end mark.
    `IFSF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(line_byte) && $stable(run_last))

    // Every accepted input is later seen with out_valid high, once it has passed the queue and the output register.
    `IFSF_ASSERT_IMPL(a_in_to_out, clk, rst_n, in_valid && !in_stall, ##2 out_valid)

    // A full queue always comes with a byte held in the output register.
    `IFSF_ASSERT_IMPL(a_stall_busy, clk, rst_n, in_stall, out_valid)

endmodule

bind info_frame_stuffing_framer_top ifsf_checker u_ifsf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .line_byte (line_byte),
    .run_last  (run_last)
);
